[rtl/integer_to_ascii_formatter_defines.svh]
// Assertion macros shared by the RTL of the integer-to-ASCII formatter.
// Each check runs on the rising edge of i_clk and is off while reset is low.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication check.
`define I2A_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("i2a check failed");

// Next-cycle implication check.
`define I2A_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("i2a check failed");

`else

`define I2A_ASSERT_NOW(lbl, ante, cons)
`define I2A_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/i2a_pkg.sv]
package i2a_pkg;

    // Number of digit cells: enough for the longest decimal string of 64 bits.
    localparam int unsigned NUM_CELLS = 20;
    // Number of hex digits in the 64-bit value.
    localparam int unsigned NUM_NIBBLES = 16;

    // Format selector codes.
    localparam logic [2:0] FMT_D  = 3'd0;
    localparam logic [2:0] FMT_I  = 3'd1;
    localparam logic [2:0] FMT_U  = 3'd2;
    localparam logic [2:0] FMT_LX = 3'd3;
    localparam logic [2:0] FMT_UX = 3'd4;
    localparam logic [2:0] FMT_P  = 3'd5;

    // ASCII codes used for the prefixes.
    localparam logic [7:0] CHR_MINUS = 8'h2d;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_X     = 8'h78;
    localparam logic [7:0] CHR_LOW_A = 8'h61;
    localparam logic [7:0] CHR_UP_A  = 8'h41;

    // Operation applied to every cell of the digit row at once.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_DABBLE,
        OP_SHIFT
    } t_cell_op;

    // ASCII character of one digit, decimal or hex.
    function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic upper);
        logic [7:0] base;
        begin
            if (digit < 4'd10) begin
                digit_char = CHR_ZERO + {4'd0, digit};
            end else begin
                base = upper ? CHR_UP_A : CHR_LOW_A;
                digit_char = base + {4'd0, digit - 4'd10};
            end
        end
    endfunction

endpackage

[rtl/integer_to_ascii_formatter.sv]
// Integer-to-ASCII formatter for printf-style d, i, u, x, X and p conversions.
// One request (format in tuser, 64-bit value in tdata) produces 1 to 20 ASCII
// characters on the master side, most significant digit first, with no
// leading zeros and tlast on the final character; d and i print the low 32
// bits as signed, u prints 64-bit unsigned decimal, x and X print hex, p
// prints "0x" and lower-case hex, and selector codes 6 and 7 act as X. The
// digits live in a row of 20 cells, loaded when the request is taken: hex
// formats load the value's nibbles, decimal formats load zeros and then run
// a shift-and-add-3 conversion through the row, one value bit per cycle, over
// all 64 bits for u and over 32 bits for d and i. A sign or "0x" prefix then
// goes out through the output register, one character at a time as the
// output side takes them. The row then moves toward its top one place per
// cycle to drop leading zeros (at most 19 places), and each digit leaves in
// turn through the output register as the row moves up, which waits while
// the output side stalls. Skipped places and digits always add up to 20, and
// the next request is taken once the last character is in the output register.
module integer_to_ascii_formatter
    import i2a_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // [63:0] value
    input  logic [2:0]  i_s_tuser,  // [2:0] func
    // Character channel.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // [7:0] out_char
    output logic        o_m_tlast   // last
);

`include "integer_to_ascii_formatter_defines.svh"

    localparam int unsigned LEFT_W = $clog2(NUM_CELLS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_PRE0,
        S_PRE1,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [63:0]         r_bits;   // value bits still to enter the row, MSB first
    logic [6:0]          r_cnt;    // conversion steps still to run
    logic [LEFT_W-1:0]   r_left;   // digit places not yet shifted out
    logic                r_neg;
    logic                r_upper;
    logic                r_ovalid;
    logic [7:0]          r_ochar;
    logic                r_olast;

    t_cell_op            w_op;
    logic [3:0]          w_digit [NUM_CELLS];
    logic                w_carry [NUM_CELLS];
    logic [3:0]          w_load  [NUM_CELLS];
    logic [3:0]          w_top;
    logic                w_accept;
    logic                w_free;
    logic                w_out_load;
    logic                w_decimal;
    logic                w_signed;
    logic [31:0]         w_mag32;
    logic                w_skip;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_free     = !r_ovalid || i_m_tready;
    assign w_out_load = w_free && (r_state inside {S_SIGN, S_PRE0, S_PRE1, S_EMIT});
    assign w_top      = w_digit[NUM_CELLS-1];
    assign w_skip     = (w_top == 4'd0) && (r_left > LEFT_W'(1));

    // Request decode.
    assign w_signed  = (i_s_tuser == FMT_D) || (i_s_tuser == FMT_I);
    assign w_decimal = w_signed || (i_s_tuser == FMT_U);
    assign w_mag32   = i_s_tdata[31] ? 32'(32'd0 - i_s_tdata[31:0]) : i_s_tdata[31:0];

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_ochar;
    assign o_m_tlast  = r_olast;

    // Row operation for the current cycle.
    always_comb begin
        case (r_state)
            S_IDLE:  w_op = w_accept ? OP_LOAD : OP_HOLD;
            S_CONV:  w_op = OP_DABBLE;
            S_SKIP:  w_op = w_skip ? OP_SHIFT : OP_HOLD;
            S_EMIT:  w_op = w_free ? OP_SHIFT : OP_HOLD;
            default: w_op = OP_HOLD;
        endcase
    end

    // Digit row: hex loads nibbles directly, decimal starts from zero.
    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++) begin : g_cell
            if (g < NUM_NIBBLES) begin : g_nib
                assign w_load[g] = w_decimal ? 4'd0 : i_s_tdata[4*g +: 4];
            end else begin : g_zero
                assign w_load[g] = 4'd0;
            end

            if (g == 0) begin : g_first
                i2a_cell u_cell (
                    .i_clk        (i_clk),
                    .i_op         (w_op),
                    .i_load_digit (w_load[g]),
                    .i_carry_in   (r_bits[63]),
                    .i_prev_digit (4'd0),
                    .o_digit      (w_digit[g]),
                    .o_carry      (w_carry[g])
                );
            end else begin : g_next
                i2a_cell u_cell (
                    .i_clk        (i_clk),
                    .i_op         (w_op),
                    .i_load_digit (w_load[g]),
                    .i_carry_in   (w_carry[g-1]),
                    .i_prev_digit (w_digit[g-1]),
                    .o_digit      (w_digit[g]),
                    .o_carry      (w_carry[g])
                );
            end
        end
    endgenerate

    // Sequencer with the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= 7'd0;
            r_left   <= '0;
            r_neg    <= 1'b0;
            r_upper  <= 1'b0;
        end else begin
            // The output register empties on a transfer unless a new character enters.
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_left  <= LEFT_W'(NUM_CELLS);
                        r_neg   <= w_signed && i_s_tdata[31];
                        r_upper <= !((i_s_tuser == FMT_LX) || (i_s_tuser == FMT_P));
                        if (w_signed) begin
                            r_bits  <= {w_mag32, 32'd0};
                            r_cnt   <= 7'd32;
                            r_state <= S_CONV;
                        end else if (w_decimal) begin
                            r_bits  <= i_s_tdata;
                            r_cnt   <= 7'd64;
                            r_state <= S_CONV;
                        end else if (i_s_tuser == FMT_P) begin
                            r_state <= S_PRE0;
                        end else begin
                            r_state <= S_SKIP;
                        end
                    end
                end
                S_CONV: begin
                    r_bits <= {r_bits[62:0], 1'b0};
                    r_cnt  <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_state <= r_neg ? S_SIGN : S_SKIP;
                    end
                end
                S_SIGN: begin
                    if (w_free) begin
                        r_ochar  <= CHR_MINUS;
                        r_olast  <= 1'b0;
                        r_state  <= S_SKIP;
                    end
                end
                S_PRE0: begin
                    if (w_free) begin
                        r_ochar  <= CHR_ZERO;
                        r_olast  <= 1'b0;
                        r_state  <= S_PRE1;
                    end
                end
                S_PRE1: begin
                    if (w_free) begin
                        r_ochar  <= CHR_X;
                        r_olast  <= 1'b0;
                        r_state  <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    if (w_skip) begin
                        r_left <= r_left - LEFT_W'(1);
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_free) begin
                        r_ochar  <= digit_char(w_top, r_upper);
                        r_olast  <= (r_left == LEFT_W'(1));
                        r_left   <= r_left - LEFT_W'(1);
                        if (r_left == LEFT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Consistency checks on the sequencer.
    `I2A_ASSERT_NOW(a_conv_cnt, r_state == S_CONV, r_cnt != 7'd0)
    `I2A_ASSERT_NOW(a_emit_left, r_state == S_EMIT, r_left != '0)
    `I2A_ASSERT_NOW(a_skip_left, r_state == S_SKIP, r_left <= LEFT_W'(NUM_CELLS) && r_left != '0)
    `I2A_ASSERT_NEXT(a_last_idle, r_state == S_EMIT && w_free && r_left == LEFT_W'(1),
        r_state == S_IDLE && r_ovalid && r_olast)

endmodule

[rtl/i2a_cell.sv]
// One digit cell of the row. It holds a single decimal or hex digit. During
// binary-to-decimal conversion it does one add-3-and-shift step per cycle,
// taking a bit from its lower neighbor and passing its top bit upward. During
// output it takes the digit of its lower neighbor, so the row moves toward
// the most significant end one place per cycle, except on a hold operation.
module i2a_cell
    import i2a_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_op   i_op,
    input  logic [3:0] i_load_digit,  // digit written on a load
    input  logic       i_carry_in,    // bit from the lower cell on a conversion step
    input  logic [3:0] i_prev_digit,  // digit of the lower cell on a shift
    output logic [3:0] o_digit,
    output logic       o_carry        // bit passed to the upper cell
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // Decimal correction before the shift keeps the digit in BCD range.
    assign w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    // Next digit for each row operation.
    always_comb begin
        case (i_op)
            OP_LOAD:   n_digit = i_load_digit;
            OP_DABBLE: n_digit = {w_adj[2:0], i_carry_in};
            OP_SHIFT:  n_digit = i_prev_digit;
            default:   n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

[tb/integer_to_ascii_formatter_test.sv]
`timescale 1ns / 100ps

module integer_to_ascii_formatter_test;
    import i2a_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_PER_PHASE = 35;
    localparam int unsigned HOLD_OFF_CYCLES = 1500;
    localparam int unsigned DRAIN_CYCLES = 120;

    // One character of formatted text as it should appear on the master side.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    // Holds the characters still owed by the block and checks each one that leaves it.
    class ascii_scoreboard;
        t_text_char expected_chars[$];
        int unsigned error_count;

        function new();
            error_count = 0;
        endfunction

        // Works out the text of one accepted request and queues it.
        function void note_request(input logic [2:0] fmt, input logic [63:0] value);
            logic [63:0] mag;
            logic [63:0] radix;
            logic [31:0] word;
            logic [7:0]  letter_base;
            logic [7:0]  digit_chars[$];
            logic [3:0]  digit;
            t_text_char  item;
            begin
                mag = value;
                radix = 64'd16;
                letter_base = CHR_LOW_A;
                item.last = 1'b0;
                case (fmt)
                    FMT_D, FMT_I: begin
                        // Signed 32-bit decimal; the word itself is negated, so the
                        // most negative value keeps its full magnitude.
                        word = value[31:0];
                        radix = 64'd10;
                        if (word[31]) begin
                            item.ch = CHR_MINUS;
                            expected_chars.push_back(item);
                            word = 32'd0 - word;
                        end
                        mag = {32'd0, word};
                    end
                    FMT_U: begin
                        radix = 64'd10;
                    end
                    FMT_LX: begin
                    end
                    FMT_P: begin
                        item.ch = CHR_ZERO;
                        expected_chars.push_back(item);
                        item.ch = CHR_X;
                        expected_chars.push_back(item);
                    end
                    default: begin
                        // Upper-case hex, also taken by the unused selector codes.
                        letter_base = CHR_UP_A;
                    end
                endcase

                // Digits come out least significant first; zero still gives one digit.
                do begin
                    digit = 4'(mag % radix);
                    if (digit < 4'd10) begin
                        digit_chars.push_front(CHR_ZERO + 8'(digit));
                    end else begin
                        digit_chars.push_front(letter_base + 8'(digit) - 8'd10);
                    end
                    mag = mag / radix;
                end while (mag != 64'd0);

                foreach (digit_chars[k]) begin
                    item.ch = digit_chars[k];
                    item.last = (k == digit_chars.size() - 1);
                    expected_chars.push_back(item);
                end
            end
        endfunction

        // Compares one transfer from the block with the oldest owed character.
        function void check_char(input logic [7:0] ch, input logic last);
            t_text_char want;
            begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected character: out_char %h, last %b", ch, last);
                    error_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (want.ch !== ch) begin
                        $error("out_char mismatch: expected %h, actual %h", want.ch, ch);
                        error_count++;
                    end
                    if (want.last !== last) begin
                        $error("last mismatch: expected %b, actual %b", want.last, last);
                        error_count++;
                    end
                end
            end
        endfunction

        function int unsigned pending();
            return expected_chars.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;  // [63:0] value
    logic [2:0]  i_s_tuser;  // [2:0] func
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;  // [7:0] out_char
    logic        o_m_tlast;

    int unsigned idle_pct;
    int unsigned stall_pct;
    logic        hold_off;
    int unsigned cycle_count;
    ascii_scoreboard text_board;

    integer_to_ascii_formatter u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = 64'd0;
        i_s_tuser = FMT_D;
        i_m_tready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b0;
        cycle_count = 0;
        text_board = new();
    end

    always #4 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("integer_to_ascii_formatter test failed");
            $finish;
        end
    end

    // Character receiver: random stalls, or a full stop during a hold-off.
    always @(negedge i_clk) begin
        i_m_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // Every character transfer goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            text_board.check_char(o_m_tdata, o_m_tlast);
        end
    end

    // Offers one request after an optional idle gap and waits for its transfer.
    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_request(input logic [2:0] fmt, input logic [63:0] value);
        begin
            if ($urandom_range(99) < idle_pct) begin
                i_s_tvalid <= 1'b0;
                do begin
                    @(negedge i_clk);
                end while ($urandom_range(99) < idle_pct);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata <= value;
            i_s_tuser <= fmt;
            do begin
                @(posedge i_clk);
            end while (!o_s_tready);
            text_board.note_request(fmt, value);
            @(negedge i_clk);
        end
    endtask

    // Value mix: full width, short numbers, small negatives, powers of two and edges.
    function automatic logic [63:0] random_value();
        logic [63:0] full;
        begin
            full = {$urandom, $urandom};
            case ($urandom_range(5))
                0: random_value = full;
                1: random_value = 64'($urandom_range(99));
                2: random_value = {full[63:32], 32'hffff_ff00 | 32'(full[7:0])};
                3: random_value = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
                4: random_value = full >> $urandom_range(63);
                default: random_value = $urandom_range(1) ? {64{1'b1}} : 64'd0;
            endcase
        end
    endfunction

    task automatic set_idling(input int unsigned send_idle, input int unsigned recv_stall);
        begin
            @(posedge i_clk);
            idle_pct = send_idle;
            stall_pct = recv_stall;
            @(negedge i_clk);
        end
    endtask

    task automatic send_random(input int unsigned count);
        begin
            repeat (count) begin
                send_request(3'($urandom_range(7)), random_value());
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests: every format, zero, field extremes and the odd cases.
        send_request(FMT_D, 64'd0);
        send_request(FMT_D, 64'h0000_0000_7fff_ffff);
        send_request(FMT_D, 64'h0000_0000_8000_0000);
        send_request(FMT_D, 64'hffff_ffff_ffff_ffff);
        send_request(FMT_I, 64'hdead_beef_0000_007b);
        send_request(FMT_I, 64'h1234_5678_ffff_ff85);
        send_request(FMT_U, 64'd0);
        send_request(FMT_U, 64'd9);
        send_request(FMT_U, 64'hffff_ffff_ffff_ffff);
        send_request(FMT_U, 64'd10000000000000000000);
        send_request(FMT_LX, 64'd0);
        send_request(FMT_LX, 64'hffff_ffff_ffff_ffff);
        send_request(FMT_LX, 64'h0123_4567_89ab_cdef);
        send_request(FMT_UX, 64'hfedc_ba98_7654_3210);
        send_request(FMT_UX, 64'd10);
        send_request(FMT_P, 64'd0);
        send_request(FMT_P, 64'hffff_ffff_ffff_ffff);
        send_request(3'd6, 64'h0000_0000_0000_0abc);
        send_request(3'd7, 64'h8000_0000_0000_000f);

        // Long receiver stop while requests keep coming, so the block backs up.
        fork
            begin
                @(posedge i_clk);
                hold_off = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        send_random(RANDOM_PER_PHASE);

        set_idling(60, 0);
        send_random(RANDOM_PER_PHASE);
        set_idling(0, 60);
        send_random(RANDOM_PER_PHASE);
        set_idling(7, 7);
        send_random(RANDOM_PER_PHASE);

        i_s_tvalid <= 1'b0;
        while (text_board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (text_board.error_count == 0 && text_board.pending() == 0) begin
            $display("integer_to_ascii_formatter test passed");
        end else begin
            $display("integer_to_ascii_formatter test failed");
        end
        $finish;
    end

endmodule
